// ----- rtl/moving_average_crossover_detector_unit_defines.svh -----
// Assertion helpers shared by the crossover detector RTL.
`ifndef MOVING_AVERAGE_CROSSOVER_DETECTOR_UNIT_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MACX_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("macx: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MACX_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("macx: assertion failed");

`endif

// ----- rtl/macx_pkg.sv -----
package macx_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int PRICE_BITS_DEF   = 32;

  // register field widths
  localparam int SW_W       = 6;
  localparam int LW_W       = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = 8;   // holds long window plus one

  localparam logic [SW_W-1:0] SHORT_RESET = 6'd10;
  localparam logic [LW_W-1:0] LONG_RESET  = 7'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WINDOW  = 1'b1;

  localparam logic [1:0] REL_BELOW = 2'd0;
  localparam logic [1:0] REL_EQUAL = 2'd1;
  localparam logic [1:0] REL_ABOVE = 2'd2;

  localparam logic [1:0] SIG_HOLD = 2'd0;
  localparam logic [1:0] SIG_BUY  = 2'd1;
  localparam logic [1:0] SIG_SELL = 2'd2;

  localparam logic signed [31:0] BUY_QTY = 32'sd100;

  localparam int QUEUE_DEPTH = 4;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QL_W        = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [SW_W-1:0] se;
    logic [LW_W-1:0] le;
  } win_t;

  // classified tick handed from front to back
  typedef struct packed {
    logic [31:0]        price;
    logic [63:0]        tick_time;
    logic signed [31:0] qty;
    logic [31:0]        drop_short;
    logic [31:0]        drop_long;
    logic               warm;
  } entry_t;

endpackage

// ----- rtl/macx_tick_if.sv -----
interface macx_tick_if;
  logic               valid;
  logic               ready;
  logic [31:0]        close_price;
  logic [63:0]        tick_time;
  logic signed [31:0] position_size;

  modport source (output valid, close_price, tick_time, position_size, input ready);
  modport sink (input valid, close_price, tick_time, position_size, output ready);
endinterface

// ----- rtl/macx_signal_if.sv -----
interface macx_signal_if;
  logic               valid;
  logic               ready;
  logic [1:0]         signal_kind;
  logic [63:0]        signal_time;
  logic [31:0]        signal_price;
  logic signed [31:0] signal_quantity;

  modport source (output valid, signal_kind, signal_time, signal_price, signal_quantity,
                  input ready);
  modport sink (input valid, signal_kind, signal_time, signal_price, signal_quantity,
                output ready);
endinterface

// ----- rtl/macx_ram.sv -----
module macx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read-first: a read of the slot being written returns the old value
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/macx_queue.sv -----
`include "moving_average_crossover_detector_unit_defines.svh"

module macx_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  macx_pkg::entry_t         push_entry,
  input  logic                     pop,
  output macx_pkg::entry_t         head,
  output logic [macx_pkg::QL_W-1:0] level
);

  macx_pkg::entry_t             slots_r [macx_pkg::QUEUE_DEPTH];
  logic [macx_pkg::QP_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [macx_pkg::QP_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [macx_pkg::QL_W-1:0]    level_r, level_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == macx_pkg::QP_W'(macx_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == macx_pkg::QP_W'(macx_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   level_nxt = level_r + 1'b1;
      2'b01:   level_nxt = level_r - 1'b1;
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = slots_r[rd_ptr_r];
  assign level = level_r;

  `MACX_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, level_r < macx_pkg::QL_W'(macx_pkg::QUEUE_DEPTH))
  `MACX_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, level_r != '0)

endmodule

// ----- rtl/macx_front.sv -----
`include "moving_average_crossover_detector_unit_defines.svh"

module macx_front #(
  parameter int WINDOW_DEPTH = macx_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = macx_pkg::PRICE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  macx_pkg::win_t            win,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [31:0]               close_price,
  input  logic [63:0]               tick_time,
  input  logic signed [31:0]        position_size,
  input  logic [macx_pkg::QL_W-1:0] q_level,
  output logic                      push,
  output macx_pkg::entry_t          push_entry
);

  localparam int PriceW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int SlotW  = $clog2(WINDOW_DEPTH);
  localparam int AddW   = SlotW + 1;
  localparam int CntW   = macx_pkg::CNT_W;

  logic [SlotW-1:0]   slot_r, slot_nxt;
  logic [CntW-1:0]    ticks_r, ticks_nxt;
  logic               f_vld_r;
  logic [PriceW-1:0]  f_price_r;
  logic [63:0]        f_time_r;
  logic signed [31:0] f_qty_r;
  logic               f_sub_s_r, f_sub_l_r, f_warm_r;

  logic               accept;
  logic [PriceW-1:0]  price;
  logic [AddW-1:0]    raw_s, raw_l;
  logic [SlotW-1:0]   addr_s, addr_l;
  logic [PriceW-1:0]  rd_s, rd_l;
  logic [CntW-1:0]    cnt_inc, cnt_lim;
  logic               sub_s, sub_l;

  // one slot for the tick in flight to the queue, plus what is already queued
  assign in_ready = ({1'b0, q_level} + (macx_pkg::QL_W + 1)'(f_vld_r)) <
                    (macx_pkg::QL_W + 1)'(macx_pkg::QUEUE_DEPTH);
  assign accept   = in_valid && in_ready;
  assign price    = close_price[PriceW-1:0];

  always_comb begin
    raw_s  = {1'b0, slot_r} + AddW'(WINDOW_DEPTH) - AddW'(win.se);
    raw_l  = {1'b0, slot_r} + AddW'(WINDOW_DEPTH) - AddW'(win.le);
    addr_s = (raw_s >= AddW'(WINDOW_DEPTH)) ? SlotW'(raw_s - AddW'(WINDOW_DEPTH)) :
                                              raw_s[SlotW-1:0];
    addr_l = (raw_l >= AddW'(WINDOW_DEPTH)) ? SlotW'(raw_l - AddW'(WINDOW_DEPTH)) :
                                              raw_l[SlotW-1:0];
    slot_nxt = (slot_r == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    sub_s    = ticks_r >= CntW'(win.se);
    sub_l    = ticks_r >= CntW'(win.le);
    cnt_inc  = ticks_r + 1'b1;
    cnt_lim  = CntW'(win.le) + 1'b1;
    ticks_nxt = (cnt_inc > cnt_lim) ? cnt_lim : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      ticks_r <= '0;
      f_vld_r <= 1'b0;
    end else if (clear) begin
      slot_r  <= '0;
      ticks_r <= '0;
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= accept;
      if (accept) begin
        slot_r  <= slot_nxt;
        ticks_r <= ticks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_price_r <= price;
      f_time_r  <= tick_time;
      f_qty_r   <= position_size;
      f_sub_s_r <= sub_s;
      f_sub_l_r <= sub_l;
      f_warm_r  <= (ticks_nxt == cnt_lim);
    end
  end

  macx_ram #(.WIDTH(PriceW), .DEPTH(WINDOW_DEPTH)) u_ring_short (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_r),
    .wdata (price),
    .raddr (addr_s),
    .rdata (rd_s)
  );

  macx_ram #(.WIDTH(PriceW), .DEPTH(WINDOW_DEPTH)) u_ring_long (
    .clk   (clk),
    .we    (accept),
    .waddr (slot_r),
    .wdata (price),
    .raddr (addr_l),
    .rdata (rd_l)
  );

  // ring data for the tick accepted last cycle is valid now
  always_comb begin
    push                  = f_vld_r;
    push_entry.price      = 32'(f_price_r);
    push_entry.tick_time  = f_time_r;
    push_entry.qty        = f_qty_r;
    push_entry.drop_short = f_sub_s_r ? 32'(rd_s) : '0;
    push_entry.drop_long  = f_sub_l_r ? 32'(rd_l) : '0;
    push_entry.warm       = f_warm_r;
  end

  `MACX_ASSERT_IMPL(a_ticks_bound, clk, rst_n, 1'b1, ticks_r <= CntW'(win.le) + CntW'(1))

endmodule

// ----- rtl/macx_back.sv -----
`include "moving_average_crossover_detector_unit_defines.svh"

module macx_back #(
  parameter int PRICE_BITS = macx_pkg::PRICE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      clear,
  input  macx_pkg::win_t            win,
  input  macx_pkg::entry_t          head,
  input  logic [macx_pkg::QL_W-1:0] q_level,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_kind,
  output logic [63:0]               out_time,
  output logic [31:0]               out_price,
  output logic signed [31:0]        out_qty
);

  localparam int PriceW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int TotW   = PriceW + macx_pkg::LW_W;
  localparam int ProdW  = TotW + macx_pkg::LW_W;

  logic               en;
  logic [TotW-1:0]    s_tot_r, l_tot_r;
  logic [1:0]         last_rel_r;

  logic               b1_vld_r, b2_vld_r;
  logic [31:0]        b1_price_r, b2_price_r;
  logic [63:0]        b1_time_r, b2_time_r;
  logic signed [31:0] b1_qty_r, b2_qty_r;
  logic               b1_warm_r, b2_warm_r;
  logic [ProdW-1:0]   prod_s_r, prod_l_r;

  logic               out_vld_r;
  logic [1:0]         out_kind_r;
  logic [63:0]        out_time_r;
  logic [31:0]        out_price_r;
  logic signed [31:0] out_qty_r;

  logic [1:0]         rel;
  logic [1:0]         kind;

  // whole back pipeline moves when the output register is free
  assign en  = !out_vld_r || out_ready;
  assign pop = en && (q_level != '0);

  always_comb begin
    if (prod_s_r < prod_l_r) begin
      rel = macx_pkg::REL_BELOW;
    end else if (prod_s_r == prod_l_r) begin
      rel = macx_pkg::REL_EQUAL;
    end else begin
      rel = macx_pkg::REL_ABOVE;
    end
    kind = macx_pkg::SIG_HOLD;
    if (b2_warm_r) begin
      if (last_rel_r != macx_pkg::REL_ABOVE && rel == macx_pkg::REL_ABOVE) begin
        kind = macx_pkg::SIG_BUY;
      end else if (last_rel_r != macx_pkg::REL_BELOW && rel == macx_pkg::REL_BELOW) begin
        kind = macx_pkg::SIG_SELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_tot_r    <= '0;
      l_tot_r    <= '0;
      last_rel_r <= macx_pkg::REL_BELOW;
      b1_vld_r   <= 1'b0;
      b2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (clear) begin
      s_tot_r    <= '0;
      l_tot_r    <= '0;
      last_rel_r <= macx_pkg::REL_BELOW;
      b1_vld_r   <= 1'b0;
      b2_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
    end else if (en) begin
      b1_vld_r  <= pop;
      b2_vld_r  <= b1_vld_r;
      out_vld_r <= b2_vld_r;
      if (pop) begin
        s_tot_r <= s_tot_r - TotW'(head.drop_short) + TotW'(head.price);
        l_tot_r <= l_tot_r - TotW'(head.drop_long) + TotW'(head.price);
      end
      if (b2_vld_r) begin
        last_rel_r <= rel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_price_r <= head.price;
      b1_time_r  <= head.tick_time;
      b1_qty_r   <= head.qty;
      b1_warm_r  <= head.warm;

      // cross-multiply: short_total * long_window vs long_total * short_window
      prod_s_r   <= ProdW'(s_tot_r) * ProdW'(win.le);
      prod_l_r   <= ProdW'(l_tot_r) * ProdW'(win.se);
      b2_price_r <= b1_price_r;
      b2_time_r  <= b1_time_r;
      b2_qty_r   <= b1_qty_r;
      b2_warm_r  <= b1_warm_r;

      out_kind_r  <= kind;
      out_time_r  <= b2_time_r;
      out_price_r <= (kind != macx_pkg::SIG_HOLD) ? b2_price_r : '0;
      out_qty_r   <= (kind == macx_pkg::SIG_BUY)  ? macx_pkg::BUY_QTY :
                     (kind == macx_pkg::SIG_SELL) ? b2_qty_r : '0;
    end
  end

  assign out_valid = out_vld_r;
  assign out_kind  = out_kind_r;
  assign out_time  = out_time_r;
  assign out_price = out_price_r;
  assign out_qty   = out_qty_r;

  `MACX_ASSERT_IMPL(a_buy_above, clk, rst_n, out_vld_r && out_kind_r == macx_pkg::SIG_BUY, last_rel_r == macx_pkg::REL_ABOVE)
  `MACX_ASSERT_IMPL(a_sell_below, clk, rst_n, out_vld_r && out_kind_r == macx_pkg::SIG_SELL, last_rel_r == macx_pkg::REL_BELOW)
  `MACX_ASSERT_NEXT(a_result_held, clk, rst_n, out_vld_r && !out_ready && !clear, $stable(last_rel_r))

endmodule

// ----- rtl/moving_average_crossover_detector_unit.sv -----
// Simple moving-average crossover detector.
// in_tick (valid/ready): one market tick per transaction: close price, timestamp
// and the held position size. out_signal (valid/ready): exactly one result per
// tick, in order: hold, buy (price, quantity 100) or sell (price, position size).
// cfg_we/cfg_idx/cfg_data: index 0 is the short window, index 1 the long window.
// Any write clears the price history; write only while the block is idle.
// Path: front register, queue, back stages b1 and b2, then the output register.
// Throughput: one tick per cycle while out_signal does not stall; the two ring
// reads per tick come from two copies of the price ring, each with one write and
// one read port, and each running sum takes one add and one subtract per tick.
// The front part writes the ring and issues the reads; it passes each tick
// through a four-entry queue to the back part, which updates the sums,
// cross-multiplies and compares.
// Reset: windows go to 10 and 30, history is empty, no result is pending.
// When out_signal stalls, the result register holds, the back part stops, the
// queue fills and in_tick ready drops once the queue has no room.
module moving_average_crossover_detector_unit #(
  parameter int WINDOW_DEPTH = macx_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = macx_pkg::PRICE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [macx_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [macx_pkg::CFG_DATA_W-1:0] cfg_data,
  macx_tick_if.sink                       in_tick,
  macx_signal_if.source                   out_signal
);

  localparam int DepthCap = (WINDOW_DEPTH < 127) ? WINDOW_DEPTH : 127;

  logic [macx_pkg::SW_W-1:0] sw_r;
  logic [macx_pkg::LW_W-1:0] lw_r;
  macx_pkg::win_t            win;
  macx_pkg::entry_t          push_entry, head;
  logic                      push, pop;
  logic [macx_pkg::QL_W-1:0] q_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= macx_pkg::SHORT_RESET;
      lw_r <= macx_pkg::LONG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        macx_pkg::CFG_SHORT_WINDOW: sw_r <= cfg_data[macx_pkg::SW_W-1:0];
        macx_pkg::CFG_LONG_WINDOW:  lw_r <= cfg_data[macx_pkg::LW_W-1:0];
      endcase
    end
  end

  // effective windows: long in 1..min(depth, 127), short in 1..long
  always_comb begin
    win.le = lw_r;
    if (lw_r == '0) begin
      win.le = macx_pkg::LW_W'(1);
    end else if (lw_r > macx_pkg::LW_W'(DepthCap)) begin
      win.le = macx_pkg::LW_W'(DepthCap);
    end
    win.se = sw_r;
    if (sw_r == '0) begin
      win.se = macx_pkg::SW_W'(1);
    end else if ({1'b0, sw_r} > win.le) begin
      win.se = win.le[macx_pkg::SW_W-1:0];
    end
  end

  macx_front #(.WINDOW_DEPTH(WINDOW_DEPTH), .PRICE_BITS(PRICE_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .clear         (cfg_we),
    .win           (win),
    .in_valid      (in_tick.valid),
    .in_ready      (in_tick.ready),
    .close_price   (in_tick.close_price),
    .tick_time     (in_tick.tick_time),
    .position_size (in_tick.position_size),
    .q_level       (q_level),
    .push          (push),
    .push_entry    (push_entry)
  );

  macx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .level      (q_level)
  );

  macx_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_we),
    .win       (win),
    .head      (head),
    .q_level   (q_level),
    .pop       (pop),
    .out_valid (out_signal.valid),
    .out_ready (out_signal.ready),
    .out_kind  (out_signal.signal_kind),
    .out_time  (out_signal.signal_time),
    .out_price (out_signal.signal_price),
    .out_qty   (out_signal.signal_quantity)
  );

endmodule
